// ===== rtl/ncto_pkg.sv =====
// ncto_pkg: shared widths, transaction payload types and sequencer states
// for the nearest-circle-to-origin search core.
// No dependencies; imported by the core and its checker.
package ncto_pkg;

  // coordinate width, two's complement with 4 fraction bits
  localparam int COORD_WIDTH = 16;
  // radius is one bit narrower, unsigned
  localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
  // square sum and root widths
  localparam int SUM_WIDTH = 2 * COORD_WIDTH;
  localparam int ROOT_WIDTH = COORD_WIDTH;
  // root iteration counter
  localparam int STEP_WIDTH = $clog2(COORD_WIDTH);

  // one input circle
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic [RADIUS_WIDTH-1:0]       radius;
    logic                          last_circle;
  } circle_t;

  // one result circle
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] best_x;
    logic signed [COORD_WIDTH-1:0] best_y;
    logic [RADIUS_WIDTH-1:0]       best_radius;
  } best_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ADD,
    ST_ROOT,
    ST_DECIDE
  } state_t;

endpackage

// ===== rtl/nearest_circle_to_origin_core.sv =====
// nearest_circle_to_origin_core: keeps the circle nearest the origin over a
// set of circles and emits it on the circle flagged last.
// Depends on ncto_pkg.
//
//   channel | direction | handshake                  | payload
//   circle  | in        | circle_valid, circle_ready | circle_t
//   best    | out       | best_valid, best_ready     | best_t
//
// Each circle passes through these steps in order: accept, two squarings on
// the shared squaring multiplier, the square sum, COORD_WIDTH steps of the
// one-bit-per-cycle square root, and a compare.
// circle_ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled best channel holds the
// core in its compare step only when a further last circle is ready to emit.
// rst is synchronous, active high, and clears the sequencer, the kept flag
// and the output valid.
module nearest_circle_to_origin_core import ncto_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    circle_valid,
  output logic    circle_ready,
  input  circle_t circle,
  output logic    best_valid,
  input  logic    best_ready,
  output best_t   best
);

  state_t state, state_next;

  // working registers
  circle_t                 cur;
  logic [COORD_WIDTH-1:0]  mag_x;
  logic [COORD_WIDTH-1:0]  mag_y;
  logic [SUM_WIDTH-2:0]    prod;
  logic [SUM_WIDTH-2:0]    sq_x;
  logic [SUM_WIDTH-1:0]    radicand;
  logic [ROOT_WIDTH:0]     rem;
  logic [ROOT_WIDTH-1:0]   root;
  logic [STEP_WIDTH-1:0]   step;

  // kept circle of the current set
  logic [COORD_WIDTH-1:0]  kept_x;
  logic [COORD_WIDTH-1:0]  kept_y;
  logic [RADIUS_WIDTH-1:0] kept_radius;
  logic [ROOT_WIDTH-1:0]   kept_distance;
  logic                    have_kept;

  // magnitudes of the incoming center
  logic [COORD_WIDTH-1:0] in_ux, in_uy, in_mag_x, in_mag_y;
  assign in_ux    = circle.center_x;
  assign in_uy    = circle.center_y;
  assign in_mag_x = in_ux[COORD_WIDTH-1] ? (~in_ux + 1'b1) : in_ux;
  assign in_mag_y = in_uy[COORD_WIDTH-1] ? (~in_uy + 1'b1) : in_uy;

  // shared squaring multiplier
  logic [COORD_WIDTH-1:0] mul_a;
  logic [SUM_WIDTH-1:0]   mul_full;
  assign mul_a    = (state == ST_SQ_X) ? mag_x : mag_y;
  assign mul_full = mul_a * mul_a;

  // one square root step: bring down two radicand bits, try the next bit
  logic [ROOT_WIDTH+2:0] rem_shift, trial, rem_diff;
  logic                  root_bit;
  assign rem_shift = {rem, radicand[SUM_WIDTH-1:SUM_WIDTH-2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_bit  = (rem_shift >= trial);
  assign rem_diff  = rem_shift - trial;

  // distance and keep decision
  logic [ROOT_WIDTH-1:0] r_ext, circle_dist;
  logic                  take, out_stall;
  assign r_ext       = {1'b0, cur.radius};
  assign circle_dist = (root >= r_ext) ? (root - r_ext) : (r_ext - root);
  assign take        = !have_kept || (kept_distance > circle_dist);
  assign out_stall   = cur.last_circle && best_valid && !best_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (circle_valid) state_next = ST_SQ_X;
      ST_SQ_X:   state_next = ST_SQ_Y;
      ST_SQ_Y:   state_next = ST_ADD;
      ST_ADD:    state_next = ST_ROOT;
      ST_ROOT:   if (step == '0) state_next = ST_DECIDE;
      ST_DECIDE: if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    circle_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (circle_valid) begin
          cur   <= circle;
          mag_x <= in_mag_x;
          mag_y <= in_mag_y;
        end
      end
      ST_SQ_X: begin
        prod <= mul_full[SUM_WIDTH-2:0];
      end
      ST_SQ_Y: begin
        sq_x <= prod;
        prod <= mul_full[SUM_WIDTH-2:0];
      end
      ST_ADD: begin
        radicand <= {1'b0, sq_x} + {1'b0, prod};
        rem      <= '0;
        root     <= '0;
        step     <= STEP_WIDTH'(COORD_WIDTH - 1);
      end
      ST_ROOT: begin
        rem      <= root_bit ? rem_diff[ROOT_WIDTH:0] : rem_shift[ROOT_WIDTH:0];
        root     <= {root[ROOT_WIDTH-2:0], root_bit};
        radicand <= {radicand[SUM_WIDTH-3:0], 2'b00};
        step     <= step - 1'b1;
      end
      ST_DECIDE: begin
        if (!out_stall && take) begin
          kept_x        <= cur.center_x;
          kept_y        <= cur.center_y;
          kept_radius   <= cur.radius;
          kept_distance <= circle_dist;
        end
      end
      default: begin
      end
    endcase
  end

  // kept flag and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_kept  <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      if (state == ST_DECIDE && !out_stall) begin
        have_kept <= !cur.last_circle;
      end
      if (state == ST_DECIDE && !out_stall && cur.last_circle) begin
        best_valid <= 1'b1;
      end else if (best_valid && best_ready) begin
        best_valid <= 1'b0;
      end
    end
  end

  // result payload, from the new circle when it wins
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && !out_stall && cur.last_circle) begin
      if (take) begin
        best.best_x      <= cur.center_x;
        best.best_y      <= cur.center_y;
        best.best_radius <= cur.radius;
      end else begin
        best.best_x      <= kept_x;
        best.best_y      <= kept_y;
        best.best_radius <= kept_radius;
      end
    end
  end

endmodule

// ===== rtl/ncto_checker.sv =====
// ncto_checker: port-level assertions for the nearest-circle search core,
// attached to it by the bind at the end of this file.
// Depends on ncto_pkg and nearest_circle_to_origin_core.
module ncto_checker import ncto_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    circle_valid,
  input logic    circle_ready,
  input circle_t circle,
  input logic    best_valid,
  input logic    best_ready,
  input best_t   best
);

  // a stalled result holds
  a_best_hold: assert property (@(posedge clk) disable iff (rst)
    best_valid && !best_ready |=> best_valid && $stable(best))
    else $error("result changed or dropped while stalled");

  // an accepted circle keeps the core busy through squaring and sum
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    circle_valid && circle_ready |=>
      !circle_ready ##1 !circle_ready ##1 !circle_ready ##1 !circle_ready)
    else $error("core ready too soon after a transaction");

  // a result appears only at the end of a circle's processing
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(best_valid) |-> !$past(circle_ready))
    else $error("result raised while the core was idle");

  // a circle not flagged last never yields a result by itself
  a_no_result_midset: assert property (@(posedge clk) disable iff (rst)
    circle_valid && circle_ready && !circle.last_circle && !best_valid |=>
      !best_valid)
    else $error("result raised after a circle not flagged last");

endmodule

bind nearest_circle_to_origin_core ncto_checker u_ncto_checker (.*);

// ===== tb/nearest_circle_to_origin_core_tb.sv =====
// nearest_circle_to_origin_core_tb: self-checking testbench for the nearest-circle search core.
// A directed table, then random circle sets under several idle and stall mixes.
// Depends on ncto_pkg and nearest_circle_to_origin_core.
module nearest_circle_to_origin_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncto_pkg::*;

  logic    clk;
  logic    rst;
  logic    circle_valid;
  logic    circle_ready;
  circle_t circle;
  logic    best_valid;
  logic    best_ready;
  best_t   best;

  nearest_circle_to_origin_core dut (
    .clk          (clk),
    .rst          (rst),
    .circle_valid (circle_valid),
    .circle_ready (circle_ready),
    .circle       (circle),
    .best_valid   (best_valid),
    .best_ready   (best_ready),
    .best         (best)
  );

  // one row of the directed table
  typedef struct {
    circle_t c;
    bit      typed;
    best_t   want;
  } dir_row_t;

  dir_row_t dir_rows[$];
  best_t    nearest_q[$];
  bit       any_error = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // running search state of the predictor
  logic [COORD_WIDTH-1:0]  kept_x = '0;
  logic [COORD_WIDTH-1:0]  kept_y = '0;
  logic [RADIUS_WIDTH-1:0] kept_radius = '0;
  logic [COORD_WIDTH-1:0]  kept_dist = '0;
  bit                      have_kept = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // floor of the square root, two bits of the operand per step
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = v;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // floor(sqrt(x*x + y*y)), 4 fraction bits
  function automatic longint unsigned center_root(circle_t c);
    longint sx;
    longint sy;
    sx = $signed(c.center_x);
    sy = $signed(c.center_y);
    if (sx < 0) sx = -sx;
    if (sy < 0) sy = -sy;
    return floor_sqrt(longint'(sx * sx + sy * sy));
  endfunction

  // |root - r|
  function automatic logic [COORD_WIDTH-1:0] circle_distance(circle_t c);
    longint unsigned root;
    longint unsigned r;
    root = center_root(c);
    r = c.radius;
    return COORD_WIDTH'((root >= r) ? root - r : r - root);
  endfunction

  // fold one circle into the search, emit on the last one
  task automatic track_nearest(input circle_t c, output bit emit, output best_t res);
    logic [COORD_WIDTH-1:0] d;
    d = circle_distance(c);
    if (!have_kept || kept_dist > d) begin
      kept_x = c.center_x;
      kept_y = c.center_y;
      kept_radius = c.radius;
      kept_dist = d;
      have_kept = 1'b1;
    end
    emit = c.last_circle;
    res.best_x = kept_x;
    res.best_y = kept_y;
    res.best_radius = kept_radius;
    if (c.last_circle) begin
      have_kept = 1'b0;
      kept_x = '0;
      kept_y = '0;
      kept_radius = '0;
      kept_dist = '0;
    end
  endtask

  function automatic void add_circle(int x, int y, int r, bit last);
    dir_row_t row;
    row.c.center_x = COORD_WIDTH'(x);
    row.c.center_y = COORD_WIDTH'(y);
    row.c.radius = RADIUS_WIDTH'(r);
    row.c.last_circle = last;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  // single-circle set: the circle comes back as is
  function automatic void add_single(int x, int y, int r);
    dir_row_t row;
    row.c.center_x = COORD_WIDTH'(x);
    row.c.center_y = COORD_WIDTH'(y);
    row.c.radius = RADIUS_WIDTH'(r);
    row.c.last_circle = 1'b1;
    row.typed = 1'b1;
    row.want.best_x = COORD_WIDTH'(x);
    row.want.best_y = COORD_WIDTH'(y);
    row.want.best_radius = RADIUS_WIDTH'(r);
    dir_rows.push_back(row);
  endfunction

  // random circle: small, extreme, same-distance, near-zero-distance or full range
  function automatic circle_t random_circle(circle_t prev);
    circle_t     c;
    logic [31:0] w;
    int unsigned pick;
    longint unsigned root;
    int          edges[5] = '{-32768, -1, 0, 1, 32767};
    int          redges[4] = '{0, 1, 16384, 32767};
    w = $urandom;
    c.center_x = w[15:0];
    c.center_y = w[31:16];
    c.radius = RADIUS_WIDTH'($urandom_range(32767));
    c.last_circle = 1'b0;
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.center_x = COORD_WIDTH'(int'($urandom_range(128)) - 64);
      c.center_y = COORD_WIDTH'(int'($urandom_range(128)) - 64);
      c.radius = RADIUS_WIDTH'($urandom_range(96));
    end else if (pick < 45) begin
      c.center_x = COORD_WIDTH'(edges[$urandom_range(4)]);
      c.center_y = COORD_WIDTH'(edges[$urandom_range(4)]);
      c.radius = RADIUS_WIDTH'(redges[$urandom_range(3)]);
    end else if (pick < 60) begin
      // mirror or swap the previous center: same distance
      if ($urandom_range(1)) begin
        c.center_x = $urandom_range(1) ? -prev.center_x : prev.center_x;
        c.center_y = $urandom_range(1) ? -prev.center_y : prev.center_y;
      end else begin
        c.center_x = $urandom_range(1) ? -prev.center_y : prev.center_y;
        c.center_y = $urandom_range(1) ? -prev.center_x : prev.center_x;
      end
      c.radius = prev.radius;
    end else if (pick < 75) begin
      // radius close to the root
      root = center_root(c) + $urandom_range(4) - 2;
      if (root <= 32767) c.radius = RADIUS_WIDTH'(root);
    end
    return c;
  endfunction

  // drive one circle transaction and record what it should produce
  task automatic send_circle(circle_t c, bit typed, best_t want);
    int unsigned gap;
    bit          emit;
    best_t       res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      circle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    circle_valid <= 1'b1;
    circle <= c;
    do @(posedge clk); while (!circle_ready);
    track_nearest(c, emit, res);
    if (emit) nearest_q.push_back(typed ? want : res);
  endtask

  // park the sender until every expected result is out
  task automatic drain_results();
    circle_valid <= 1'b0;
    do @(posedge clk); while (nearest_q.size() != 0);
  endtask

  // result side: random ready, check each accepted transaction
  always @(posedge clk) begin
    if (!rst && best_valid && best_ready) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d r=%0d", $time,
                 best.best_x, best.best_y, best.best_radius);
        any_error = 1'b1;
      end else begin
        if (best.best_x !== nearest_q[0].best_x || best.best_y !== nearest_q[0].best_y ||
            best.best_radius !== nearest_q[0].best_radius) begin
          $display("%0t: mismatch, expected x=%0d y=%0d r=%0d, actual x=%0d y=%0d r=%0d",
                   $time, nearest_q[0].best_x, nearest_q[0].best_y,
                   nearest_q[0].best_radius, best.best_x, best.best_y, best.best_radius);
          any_error = 1'b1;
        end
        void'(nearest_q.pop_front());
      end
    end
    best_ready <= ($urandom_range(99) >= stall_pct);
  end

  // main sequence
  initial begin
    int unsigned sent;
    int unsigned len;
    circle_t     c;
    circle_t     prev;

    rst <= 1'b1;
    circle_valid <= 1'b0;
    circle <= '0;
    best_ready <= 1'b0;

    // single sets at the extremes
    add_single(0, 0, 0);
    add_single(-32768, -32768, 32767);
    add_single(32767, 32767, 32767);
    add_single(32767, -32768, 0);
    add_single(-1, 1, 1);
    // equal distances: the earliest circle stays
    add_circle(16, 0, 0, 0);
    add_circle(0, -16, 0, 0);
    add_circle(-16, 0, 0, 1);
    // first circle kept however far, an equal one does not replace it
    add_circle(32767, 32767, 0, 0);
    add_circle(-32767, 32767, 0, 1);
    // a closer circle replaces a far one
    add_circle(32767, 32767, 0, 0);
    add_circle(0, 0, 0, 1);
    // radius equal to the root gives zero distance
    add_circle(48, 64, 0, 0);
    add_circle(48, 64, 80, 0);
    add_circle(-48, -64, 81, 1);
    // radius beyond the root, then equal to it
    add_circle(0, 0, 32767, 0);
    add_circle(1, 1, 32767, 0);
    add_circle(3, 4, 5, 1);
    // most negative coordinates
    add_circle(-32768, 0, 32767, 0);
    add_circle(-32768, -32768, 32767, 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_circle(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // random sets under each idle and stall mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      sent = 0;
      while (sent < 150) begin
        len = $urandom_range(99);
        if (len < 10) len = 1;
        else if (len < 80) len = $urandom_range(6, 1);
        else len = $urandom_range(16, 7);
        prev = random_circle('0);
        for (int k = 0; k < len; k++) begin
          c = random_circle(prev);
          c.last_circle = (k == len - 1);
          send_circle(c, 1'b0, '0);
          prev = c;
          sent++;
        end
      end
      drain_results();
    end

    // let any stray result show up
    repeat (40) @(posedge clk);
    if (!any_error && nearest_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ncto_pkg.sv
rtl/nearest_circle_to_origin_core.sv
rtl/ncto_checker.sv
tb/nearest_circle_to_origin_core_tb.sv
